[hdl/gfe_pkg.sv]
// Shared types, constants and the GF(2^8) multiply for the chunk encoder.
// No dependencies; compiled first.
package gfe_pkg;

  localparam int CHUNK_BYTES_DEF = 1024;

  // Field widths of the channel words
  localparam int IDX_W  = 32;
  localparam int CNT_W  = 16;
  localparam int NONCE_W = 16;
  localparam int POS_W  = 11;

  // Word function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // LCG step constants, split into 32-bit halves for the shared multiplier
  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC = 64'd1442695040888963407;
  localparam logic [31:0] LCG_MUL_LO = LCG_MUL[31:0];
  localparam logic [31:0] LCG_MUL_HI = LCG_MUL[63:32];

  localparam logic [7:0] GF_POLY_LO = 8'h1b;
  localparam logic [7:0] PAD_MID    = 8'h80;
  localparam logic [7:0] PAD_FINAL  = 8'h81;

  typedef struct packed {
    logic               func;
    logic [IDX_W-1:0]   first_index;
    logic [CNT_W-1:0]   chunk_count;
    logic [NONCE_W-1:0] nonce;
    logic [7:0]         data_byte;
    logic               end_of_chunk;
    logic               final_chunk;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [7:0]       coded_byte;
    logic [7:0]       coefficient;
    logic             last_of_run;
  } out_word_t;

  // Shift-and-add product modulo x^8+x^4+x^3+x+1
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] s;
    p = 8'h00;
    s = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ s;
      s = s[7] ? ({s[6:0], 1'b0} ^ GF_POLY_LO) : {s[6:0], 1'b0};
    end
    return p;
  endfunction

endpackage

[hdl/gfe_in_if.sv]
// Input channel of the chunk encoder: valid/ready handshake plus one in_word_t.
// Depends on gfe_pkg.
interface gfe_in_if;
  import gfe_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/gfe_out_if.sv]
// Result channel of the chunk encoder: valid/ready handshake plus one out_word_t.
// Depends on gfe_pkg.
interface gfe_out_if;
  import gfe_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/gf256_random_linear_chunk_encoder_core.sv]
// Top level of the GF(2^8) random linear chunk encoder: accumulator memory,
// LCG coefficient draw on a shared 32x32 multiplier, and the output register.
// Depends on gfe_pkg, gfe_in_if and gfe_out_if.
//
//   channel  | direction | word         | handshake
//   ---------+-----------+--------------+------------------------------
//   in_ch    | in        | in_word_t    | valid & ready, start or byte
//   out_ch   | out       | out_word_t   | valid & ready, one update
//
// A start word is taken in the idle state. A byte word is accepted, read and
// written back by a read-modify-write; at end of chunk a second read and write
// add the padding byte. On a chunk's first byte a nonzero LCG state is first
// stepped (one 32x32 multiplier used 3 times and a 64-bit add). The accumulator
// is one single-port memory with a registered read. Reset takes effect at once:
// a fill count marks the written prefix of the memory, so there is no clearing
// pass. A write stage holds while the output register is full and not taken.
module gf256_random_linear_chunk_encoder_core #(
  parameter int CHUNK_BYTES = gfe_pkg::CHUNK_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gfe_in_if.sink       in_ch,
  gfe_out_if.source    out_ch
);
  import gfe_pkg::*;

  localparam int PW    = $clog2(CHUNK_BYTES + 1);
  localparam int FW    = $clog2(CHUNK_BYTES + 2);
  localparam int DEPTH = CHUNK_BYTES + 1;
  localparam logic [PW-1:0] LAST_POS = PW'(CHUNK_BYTES);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL0 = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_ADD  = 7'b0010000,
    S_RD   = 7'b0100000,
    S_WR   = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [63:0]    lcg_r, lcg_nxt;
  logic [7:0]     coef_r, coef_nxt;
  logic [PW-1:0]  byte_pos_r, byte_pos_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_word_t      out_word_r, out_word_nxt;

  // Per-word working registers
  logic [PW-1:0]  cur_pos_r, cur_pos_nxt;
  logic [7:0]     opnd_r, opnd_nxt;
  logic           eoc_r, eoc_nxt;
  logic           fin_r, fin_nxt;
  logic           pad_r, pad_nxt;
  logic [63:0]    p0_r, p0_nxt;
  logic [31:0]    hi_r, hi_nxt;

  // Accumulator memory
  logic [7:0]     acc_mem [DEPTH];
  logic [7:0]     rd_data_r;
  logic           rd_hit_r;
  logic           mem_re;
  logic           mem_we;
  logic [7:0]     mem_wdata;

  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [63:0]    mul_p;
  logic [63:0]    lcg_step;
  logic [63:0]    seed;
  logic [7:0]     acc_new;
  logic [PW-1:0]  pad_pos;
  logic           out_free;
  logic           in_fire;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Shared multiplier: low and cross products of the 64-bit LCG multiply
  always_comb begin
    unique case (state_r)
      S_MUL0:  begin mul_a = lcg_r[31:0];  mul_b = LCG_MUL_LO; end
      S_MUL1:  begin mul_a = lcg_r[63:32]; mul_b = LCG_MUL_LO; end
      S_MUL2:  begin mul_a = lcg_r[31:0];  mul_b = LCG_MUL_HI; end
      default: begin mul_a = lcg_r[31:0];  mul_b = LCG_MUL_LO; end
    endcase
  end

  assign mul_p    = 64'(mul_a) * 64'(mul_b);
  assign lcg_step = p0_r + {hi_r, 32'h0000_0000};
  assign acc_new  = (rd_hit_r ? rd_data_r : 8'h00) ^ gf_mul(opnd_r, coef_r);
  assign pad_pos  = (cur_pos_r < LAST_POS) ? cur_pos_r + PW'(1) : LAST_POS;

  always_comb begin
    logic [NONCE_W-1:0] nonce_eff;
    nonce_eff = (in_ch.data.nonce == '0) ? NONCE_W'(1) : in_ch.data.nonce;
    seed = (in_ch.data.chunk_count <= CNT_W'(1)) ? 64'h0 :
           {nonce_eff, in_ch.data.chunk_count, in_ch.data.first_index};
  end

  always_comb begin
    state_nxt     = state_r;
    lcg_nxt       = lcg_r;
    coef_nxt      = coef_r;
    byte_pos_nxt  = byte_pos_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    cur_pos_nxt   = cur_pos_r;
    opnd_nxt      = opnd_r;
    eoc_nxt       = eoc_r;
    fin_nxt       = fin_r;
    pad_nxt       = pad_r;
    p0_nxt        = p0_r;
    hi_nxt        = hi_r;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = acc_new;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.func == FUNC_START) begin
            // An empty fill count reads the whole accumulator as zero
            fill_nxt     = '0;
            lcg_nxt      = seed;
            coef_nxt     = 8'h01;
            byte_pos_nxt = '0;
          end else begin
            cur_pos_nxt = byte_pos_r;
            opnd_nxt    = in_ch.data.data_byte;
            eoc_nxt     = in_ch.data.end_of_chunk;
            fin_nxt     = in_ch.data.final_chunk;
            pad_nxt     = 1'b0;
            if (byte_pos_r == '0 && lcg_r != 64'h0) begin
              state_nxt = S_MUL0;
            end else begin
              if (byte_pos_r == '0) coef_nxt = 8'h01;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_MUL0: begin
        p0_nxt    = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        p0_nxt    = p0_r + LCG_INC;
        hi_nxt    = mul_p[31:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        hi_nxt    = hi_r + mul_p[31:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        lcg_nxt = lcg_step;
        // Repeat the step on a zero state or a zero top byte
        if (lcg_step == 64'h0 || lcg_step[63:56] == 8'h00) begin
          state_nxt = S_MUL0;
        end else begin
          coef_nxt  = lcg_step[63:56];
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          mem_we                   = 1'b1;
          out_valid_nxt            = 1'b1;
          out_word_nxt.position    = POS_W'(cur_pos_r);
          out_word_nxt.coded_byte  = acc_new;
          out_word_nxt.coefficient = coef_r;
          out_word_nxt.last_of_run = pad_r || !eoc_r;
          if (FW'(cur_pos_r) == fill_r) fill_nxt = fill_r + FW'(1);
          if (!pad_r && eoc_r) begin
            // Second pass: padding byte one position further on, saturating at the last slot
            pad_nxt     = 1'b1;
            cur_pos_nxt = pad_pos;
            opnd_nxt    = fin_r ? PAD_FINAL : PAD_MID;
            state_nxt   = S_RD;
          end else begin
            byte_pos_nxt = pad_r ? '0 : pad_pos;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lcg_r       <= 64'h0;
      coef_r      <= 8'h01;
      byte_pos_r  <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcg_r       <= lcg_nxt;
      coef_r      <= coef_nxt;
      byte_pos_r  <= byte_pos_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    cur_pos_r  <= cur_pos_nxt;
    opnd_r     <= opnd_nxt;
    eoc_r      <= eoc_nxt;
    fin_r      <= fin_nxt;
    pad_r      <= pad_nxt;
    p0_r       <= p0_nxt;
    hi_r       <= hi_nxt;
  end

  // Single-port accumulator; entries at or beyond the fill count read as zero
  always_ff @(posedge clk) begin
    if (mem_we) acc_mem[cur_pos_r] <= mem_wdata;
    if (mem_re) begin
      rd_data_r <= acc_mem[cur_pos_r];
      rd_hit_r  <= (FW'(cur_pos_r) < fill_r);
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(DEPTH) >= fill_r)
    else $error("fill count beyond memory depth");

  a_write_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (FW'(cur_pos_r) <= fill_r))
    else $error("accumulator write leaves a gap in the filled prefix");

  a_coef_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    coef_r != 8'h00)
    else $error("zero coefficient");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_pos_r <= LAST_POS) && (cur_pos_r <= LAST_POS || state_r == S_IDLE))
    else $error("byte position past the last slot");

  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WR))
    else $error("output word raised outside the write stage");

endmodule

[tb/gf256_random_linear_chunk_encoder_core_test.sv]
// Self-checking bench for gf256_random_linear_chunk_encoder_core: drives start and byte
// words, predicts every coded-byte update in a local encoder and compares each result.
// Depends on gfe_pkg, gfe_in_if, gfe_out_if and the core.
module gf256_random_linear_chunk_encoder_core_test;
  import gfe_pkg::*;

  localparam int          CHUNK      = CHUNK_BYTES_DEF;
  localparam int          CYCLE_CAP  = 500000;
  localparam int          HOLD_LEN   = 400;
  localparam logic [63:0] LCG_A      = 64'd6364136223846793005;
  localparam logic [63:0] LCG_C      = 64'd1442695040888963407;
  localparam logic [7:0]  GF_RED     = 8'h1b;
  localparam logic [7:0]  PAD_INNER  = 8'h80;
  localparam logic [7:0]  PAD_LAST   = 8'h81;

  logic clk;
  logic rst_n;

  gfe_in_if  in_ch ();
  gfe_out_if out_ch ();

  gf256_random_linear_chunk_encoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_word_t    word_q[$];
  out_word_t   coded_q[$];
  int unsigned n_pushed;
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;
  logic        in_took;
  logic        hold_armed;
  logic        rx_hold;

  // local copy of the encoder state
  logic [7:0]  acc_mem [0:CHUNK];
  logic [63:0] lcg;
  logic [7:0]  cur_coef;
  int unsigned pos_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] p;
    p = 8'h00;
    // Horner form: shift the partial product, then add x for each set bit of y
    for (int k = 7; k >= 0; k--) begin
      p = {p[6:0], 1'b0} ^ (p[7] ? GF_RED : 8'h00);
      if (y[k]) p = p ^ x;
    end
    return p;
  endfunction

  function automatic logic [7:0] step_coefficient();
    logic [7:0] v;
    if (lcg == 64'd0) return 8'd1;
    do begin
      lcg = lcg * LCG_A + LCG_C;
      v   = lcg[63:56];
    end while (lcg == 64'd0 || v == 8'd0);
    return v;
  endfunction

  task automatic encode_word(input in_word_t w);
    out_word_t   r;
    int unsigned slot;
    int unsigned pad_slot;
    if (w.func == FUNC_START) begin
      foreach (acc_mem[i]) acc_mem[i] = 8'h00;
      if (w.chunk_count <= 1)
        lcg = 64'd0;
      else
        lcg = {(w.nonce == '0) ? 16'd1 : w.nonce, w.chunk_count, w.first_index};
      cur_coef = 8'd1;
      pos_cnt  = 0;
    end else begin
      if (pos_cnt == 0) cur_coef = step_coefficient();
      slot = (pos_cnt > CHUNK) ? CHUNK : pos_cnt;
      acc_mem[slot] ^= gf_times(w.data_byte, cur_coef);
      r.position    = POS_W'(slot);
      r.coded_byte  = acc_mem[slot];
      r.coefficient = cur_coef;
      r.last_of_run = !w.end_of_chunk;
      coded_q.insert(coded_q.size(), r);
      if (!w.end_of_chunk) begin
        pos_cnt = (slot < CHUNK) ? slot + 1 : CHUNK;
      end else begin
        // padding lands one past the data byte, folded into the last slot if full
        pad_slot = (slot < CHUNK) ? slot + 1 : CHUNK;
        acc_mem[pad_slot] ^= gf_times(w.final_chunk ? PAD_LAST : PAD_INNER, cur_coef);
        r.position    = POS_W'(pad_slot);
        r.coded_byte  = acc_mem[pad_slot];
        r.coefficient = cur_coef;
        r.last_of_run = 1'b1;
        coded_q.insert(coded_q.size(), r);
        pos_cnt = 0;
      end
    end
  endtask

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    n_errors++;
  endtask

  // fields unused by a word carry random noise
  task automatic push_start(input logic [31:0] first, input logic [15:0] count,
                            input logic [15:0] nonce);
    in_word_t w;
    w              = in_word_t'($urandom);
    w.func         = FUNC_START;
    w.first_index  = first;
    w.chunk_count  = count;
    w.nonce        = nonce;
    w.data_byte    = 8'($urandom);
    word_q.insert(word_q.size(), w);
    n_pushed++;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic eoc, input logic fin);
    in_word_t w;
    w              = in_word_t'($urandom);
    w.func         = FUNC_BYTE;
    w.first_index  = $urandom;
    w.chunk_count  = 16'($urandom);
    w.nonce        = 16'($urandom);
    w.data_byte    = data;
    w.end_of_chunk = eoc;
    w.final_chunk  = fin;
    word_q.insert(word_q.size(), w);
    n_pushed++;
  endtask

  task automatic add_traffic(input int unsigned n_words);
    int unsigned      stop_at;
    int unsigned      n_chunks;
    int unsigned      len;
    logic [15:0]      count;
    logic [15:0]      nonce;
    logic [95:0]      raw;
    in_word_t         w;
    stop_at = n_pushed + n_words;
    while (n_pushed < stop_at) begin
      if ($urandom_range(99) < 8) begin
        // stray word of any kind
        raw = {$urandom, $urandom, $urandom};
        w   = raw[$bits(in_word_t)-1:0];
        word_q.insert(word_q.size(), w);
        n_pushed++;
      end else begin
        case ($urandom_range(9))
          0:       count = 16'($urandom_range(1));
          1:       count = 16'hffff;
          default: count = 16'($urandom_range(65535, 2));
        endcase
        nonce = ($urandom_range(99) < 15) ? 16'h0000 : 16'($urandom);
        push_start($urandom, count, nonce);
        n_chunks = $urandom_range(4, 1);
        for (int c = 0; c < n_chunks; c++) begin
          len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7);
          for (int b = 1; b <= len; b++)
            push_byte(8'($urandom), b == len,
                      (b == len) && (c == n_chunks - 1) && $urandom_range(1));
        end
      end
    end
  endtask

  task automatic drain();
    while (n_accepted != n_pushed || coded_q.size() != 0) @(negedge clk);
  endtask

  // sender: hold an offered word until taken
  always @(negedge clk) begin : feed
    in_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_took) begin
    end else if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      nxt = word_q[0];
      word_q.delete(0);
      in_ch.data  <= nxt;
      in_ch.valid <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drain_side
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  initial begin : hold_off
    wait (hold_armed);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin : score
    out_word_t got;
    out_word_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        encode_word(in_ch.data);
        n_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (coded_q.size() == 0) begin
          report($sformatf("unexpected word pos=%0d byte=%02h", got.position, got.coded_byte));
        end else begin
          want = coded_q[0];
          coded_q.delete(0);
          if (got.position !== want.position)
            report($sformatf("position %0d, want %0d", got.position, want.position));
          if (got.coded_byte !== want.coded_byte)
            report($sformatf("coded_byte %02h, want %02h at pos %0d",
                             got.coded_byte, want.coded_byte, want.position));
          if (got.coefficient !== want.coefficient)
            report($sformatf("coefficient %02h, want %02h",
                             got.coefficient, want.coefficient));
          if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %0b, want %0b",
                             got.last_of_run, want.last_of_run));
        end
      end
    end
    in_took <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("gf256_random_linear_chunk_encoder_core_test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] first;
    logic [15:0] count;
    logic [15:0] nonce;
    logic [63:0] probe;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    in_took      = 1'b0;
    hold_armed   = 1'b0;
    rx_hold      = 1'b0;
    n_pushed     = 0;
    n_accepted   = 0;
    n_errors     = 0;
    cycles       = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    foreach (acc_mem[i]) acc_mem[i] = 8'h00;
    lcg      = 64'd0;
    cur_coef = 8'd1;
    pos_cnt  = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // bytes before any start use coefficient one
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hff, 1'b1, 1'b0);
    push_byte(8'ha5, 1'b1, 1'b1);
    // counts of zero and one give a zero seed
    push_start(32'h0000_0000, 16'd0, 16'h1234);
    push_byte(8'h80, 1'b1, 1'b1);
    push_start(32'hffff_ffff, 16'd1, 16'hffff);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'hfe, 1'b1, 1'b0);
    // zero nonce is replaced by one
    push_start(32'h0000_0000, 16'd2, 16'h0000);
    push_byte(8'hff, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h55, 1'b1, 1'b1);
    push_start(32'hffff_ffff, 16'hffff, 16'hffff);
    push_byte(8'hff, 1'b1, 1'b1);
    // seed whose first step has a zero top byte, forcing a repeat
    do begin
      first = $urandom;
      count = 16'($urandom_range(65535, 2));
      nonce = 16'($urandom_range(65535, 1));
      probe = {nonce, count, first} * LCG_A + LCG_C;
    end while (probe[63:56] != 8'h00);
    push_start(first, count, nonce);
    push_byte(8'h3c, 1'b0, 1'b0);
    push_byte(8'hc3, 1'b1, 1'b0);
    push_byte(8'h7e, 1'b1, 1'b1);

    // overlong chunk: position saturates at the last slot
    push_start($urandom, 16'd3, 16'($urandom));
    for (int b = 0; b < CHUNK + 6; b++) push_byte(8'($urandom), 1'b0, 1'b0);
    push_byte(8'($urandom), 1'b1, 1'b1);
    add_traffic(220);
    drain();

    // receiver holds off while the sender keeps offering
    hold_armed = 1'b1;
    add_traffic(60);
    drain();

    idle_pct  = 88;
    stall_pct = 0;
    add_traffic(220);
    drain();

    idle_pct  = 0;
    stall_pct = 88;
    add_traffic(220);
    drain();

    idle_pct  = 38;
    stall_pct = 38;
    add_traffic(220);
    drain();

    repeat (60) @(negedge clk);
    if (n_errors == 0 && coded_q.size() == 0) begin
      $display("gf256_random_linear_chunk_encoder_core_test passed");
    end else begin
      $display("gf256_random_linear_chunk_encoder_core_test failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/gfe_pkg.sv
hdl/gfe_in_if.sv
hdl/gfe_out_if.sv
hdl/gf256_random_linear_chunk_encoder_core.sv
tb/gf256_random_linear_chunk_encoder_core_test.sv
